// File: design/rlm_pkg.sv
`timescale 1ns / 1ps
package rlm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_BLOCK_LEN = 65536;

    localparam int SQ_W       = 2 * SAMPLE_BITS - 1;
    localparam int CNT_W      = $clog2(MAX_BLOCK_LEN + 1);
    localparam int SUM_W      = SQ_W + $clog2(MAX_BLOCK_LEN);
    localparam int ROOT_W     = SAMPLE_BITS;
    localparam int SQ_PAD_W   = 2 * SAMPLE_BITS;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = SAMPLE_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } block_t;

    typedef struct packed {
        logic              valid;
        logic [QCNT_W-1:0] count;
    } qstat_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SQRT
    } back_state_t;

endpackage

// File: design/rlm_front.sv
`timescale 1ns / 1ps
module rlm_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                           has_sample,
    input  logic                           is_last,
    input  rlm_pkg::qstat_t                q_stat,
    output logic                           busy,
    output logic                           q_push,
    output rlm_pkg::block_t                q_entry
);
    import rlm_pkg::*;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_PAD_W-1:0]    prod;

    logic                   s1_valid_reg;
    logic                   s1_has_reg;
    logic                   s1_last_reg;
    logic [SQ_W-1:0]        s1_sq_reg;

    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   at_max;
    logic                   take;
    logic [QCNT_W:0]        pending;

    // hold off a new word while a closing word could find the queue full
    assign pending = {1'b0, q_stat.count} + {{QCNT_W{1'b0}}, (s1_valid_reg & s1_last_reg)};
    assign busy    = (pending >= (QCNT_W + 1)'(QDEPTH));
    assign accept  = start & ~busy;

    assign mag  = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign prod = mag * mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_has_reg  <= has_sample;
            s1_last_reg <= is_last;
            s1_sq_reg   <= prod[SQ_W-1:0];
        end
    end

    assign at_max = (count_reg == CNT_W'(MAX_BLOCK_LEN));
    assign take   = s1_has_reg & ~at_max;

    always_comb
    begin
        sum_next   = take ? (sum_reg + {{(SUM_W - SQ_W){1'b0}}, s1_sq_reg}) : sum_reg;
        count_next = take ? (count_reg + 1'b1) : count_reg;
        ovf_next   = ovf_reg | (s1_has_reg & at_max);
    end

    assign q_push        = s1_valid_reg & s1_last_reg;
    assign q_entry.sum   = sum_next;
    assign q_entry.count = count_next;
    assign q_entry.ovf   = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// File: design/rlm_queue.sv
`timescale 1ns / 1ps
module rlm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rlm_pkg::block_t wr_entry,
    input  logic            pop,
    output rlm_pkg::block_t rd_entry,
    output rlm_pkg::qstat_t stat
);
    import rlm_pkg::*;

    block_t             mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : (p + 1'b1);
    endfunction

    assign rd_entry   = mem[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: design/rlm_back.sv
`timescale 1ns / 1ps
module rlm_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rlm_pkg::qstat_t             q_stat,
    input  rlm_pkg::block_t             q_entry,
    output logic                        q_pop,
    output logic                        done,
    output logic [rlm_pkg::ROOT_W-1:0]  rms_level,
    output logic                        overflow
);
    import rlm_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;

    logic               load;
    logic               emit_zero;
    logic               div_en;
    logic               sqrt_en;
    logic               emit_root;

    logic [STEP_W-1:0]  step_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [CNT_W-1:0]   div_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic               ovf_hold_reg;
    logic [ROOT_W-1:0]  sroot_reg;
    logic [SREM_W-1:0]  srem_reg;

    logic [CNT_W:0]     d_shift;
    logic               d_ge;
    logic [CNT_W:0]     d_diff;
    logic [SREM_W-1:0]  s_shift;
    logic [SREM_W-1:0]  s_trial;
    logic               s_ge;
    logic [ROOT_W-1:0]  sroot_step;

    logic               done_reg;
    logic [ROOT_W-1:0]  level_reg;
    logic               ovf_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_stat.valid && (q_entry.count != '0))
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load      = 1'b0;
        emit_zero = 1'b0;
        div_en    = 1'b0;
        sqrt_en   = 1'b0;
        emit_root = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                q_pop     = q_stat.valid;
                load      = q_stat.valid && (q_entry.count != '0);
                emit_zero = q_stat.valid && (q_entry.count == '0);
            end
            B_DIV:
            begin
                div_en = 1'b1;
            end
            B_SQRT:
            begin
                sqrt_en   = 1'b1;
                emit_root = (step_reg == STEP_W'(SQRT_STEPS - 1));
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // restoring divide, one quotient bit per cycle
    assign d_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign d_ge    = (d_shift >= {1'b0, div_reg});
    assign d_diff  = d_shift - {1'b0, div_reg};

    // digit-by-digit square root, one root bit per cycle
    assign s_shift    = {srem_reg[SREM_W-3:0], quot_reg[SQ_PAD_W-1 -: 2]};
    assign s_trial    = SREM_W'({sroot_reg, 2'b01});
    assign s_ge       = (s_shift >= s_trial);
    assign sroot_step = {sroot_reg[ROOT_W-2:0], s_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit_zero | emit_root;
            if (load)
            begin
                step_reg <= '0;
            end
            else if (div_en || sqrt_en)
            begin
                if (state_next != state_reg)
                begin
                    step_reg <= '0;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            quot_reg     <= q_entry.sum;
            div_reg      <= q_entry.count;
            rem_reg      <= '0;
            ovf_hold_reg <= q_entry.ovf;
            sroot_reg    <= '0;
            srem_reg     <= '0;
        end
        else if (div_en)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], d_ge};
            rem_reg  <= d_ge ? d_diff[CNT_W-1:0] : d_shift[CNT_W-1:0];
        end
        else if (sqrt_en)
        begin
            quot_reg  <= {quot_reg[SUM_W-3:0], 2'b00};
            srem_reg  <= s_ge ? (s_shift - s_trial) : s_shift;
            sroot_reg <= sroot_step;
        end

        if (emit_zero)
        begin
            level_reg   <= '0;
            ovf_out_reg <= q_entry.ovf;
        end
        else if (emit_root)
        begin
            level_reg   <= sroot_step;
            ovf_out_reg <= ovf_hold_reg;
        end
    end

    assign done      = done_reg;
    assign rms_level = level_reg;
    assign overflow  = ovf_out_reg;

endmodule

// File: design/block_rms_level_meter.sv
`timescale 1ns / 1ps
// RMS level meter over blocks of signed Q1.23 audio samples.
//
// Input: a word is taken at a rising edge with start high and busy low.
// has_sample marks a valid sample; is_last closes the block. A word with a
// sample squares it and adds it to the block sum; past 65536 samples further
// samples are dropped and the overflow flag of that block is set.
//
// Output: one result per closing word, shown for one cycle with done high:
// rms_level = floor(sqrt(floor(sum / count))) in unsigned Q1.23, and overflow.
// An empty block gives 0. The receiver cannot stall; results are never held.
//
// Throughput: one word per cycle while busy is low. A closing word enters a
// two-entry queue; the back end pops it, runs a bit-serial divide and a
// bit-serial square root. It pops from the queue only while idle, so it
// finishes one block before it takes the next. An empty block skips the
// divide and the square root.
// busy rises only when the queue cannot take another closing word.
//
// Reset clears the sums, the queue and the back end; no result is pending.
module block_rms_level_meter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [rlm_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                  has_sample,
    input  logic                                  is_last,
    output logic                                  done,
    output logic [rlm_pkg::ROOT_W-1:0]            rms_level,
    output logic                                  overflow
);
    import rlm_pkg::*;

    qstat_t q_stat;
    block_t q_wr_entry;
    block_t q_rd_entry;
    logic   q_push;
    logic   q_pop;

    rlm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .sample     (sample),
        .has_sample (has_sample),
        .is_last    (is_last),
        .q_stat     (q_stat),
        .busy       (busy),
        .q_push     (q_push),
        .q_entry    (q_wr_entry)
    );

    rlm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .stat     (q_stat)
    );

    rlm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_entry   (q_rd_entry),
        .q_pop     (q_pop),
        .done      (done),
        .rms_level (rms_level),
        .overflow  (overflow)
    );

`ifndef SYNTH
    a_no_queue_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && (q_stat.count == QCNT_W'(QDEPTH))) |-> q_pop)
        else $error("queue overrun");

    a_pop_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.valid)
        else $error("pop from empty queue");

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rms_level <= (ROOT_W'(1) << (SAMPLE_BITS - 1))))
        else $error("rms level out of range");
`endif

endmodule
